FILE: design/wsm_pkg.sv
`timescale 1ns / 1ps

package wsm_pkg;

  localparam int MAX_PATTERN = 64;
  localparam int COUNT_BITS  = 24;
  localparam int CHAR_W      = 8;
  localparam int ACT_W       = 2;
  localparam int PIDX_W      = 6;
  localparam int CFG_W       = 7;

  // Width of an effective length (1..MAX_PATTERN) and of a cell index.
  localparam int LEN_W = $clog2(MAX_PATTERN + 1);
  localparam int IDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  // Common width for comparing the configured length against MAX_PATTERN.
  localparam int LCMP_W = (CFG_W > LEN_W) ? CFG_W + 1 : LEN_W + 1;
  // Signed working width for the ring slot of a pattern load.
  localparam int DIFF_W = (LEN_W > PIDX_W) ? LEN_W + 1 : PIDX_W + 1;

  localparam logic [CHAR_W-1:0]     WILDCARD  = CHAR_W'(42);
  localparam logic [COUNT_BITS-1:0] COUNT_TOP = {COUNT_BITS{1'b1}};

  localparam logic [ACT_W-1:0] ACT_LOAD    = ACT_W'(0);
  localparam logic [ACT_W-1:0] ACT_TEXT    = ACT_W'(1);
  localparam logic [ACT_W-1:0] ACT_RESTART = ACT_W'(2);

  // Broadcast control for the row of cells.
  typedef struct packed {
    logic              text_en;
    logic              load_en;
    logic              rot_up;
    logic              rot_dn;
    logic [CHAR_W-1:0] chr;
  } cell_ctl_t;

  // First pipeline stage of a text beat, consumed by the result stage.
  typedef struct packed {
    logic                  valid;
    logic                  ok;
    logic [COUNT_BITS-1:0] pos;
  } stage_t;

  function automatic logic chars_agree(input logic [CHAR_W-1:0] a,
                                       input logic [CHAR_W-1:0] b);
    chars_agree = (a == b) || (a == WILDCARD) || (b == WILDCARD);
  endfunction

endpackage

FILE: design/wildcard_string_matcher.sv
`timescale 1ns / 1ps
// A text beat is registered in the stage, then in the out_valid_o register.
// Throughput: one beat of any kind per cycle while the result side keeps up.
// A change of pattern length rotates the pattern ring through the cell chain,
// one cell per cycle, so input ready stays low until the rotation is done.
// Reset (rst_ni low, asynchronous) clears pattern, window and both counters,
// and sets the pattern length to one.

module wildcard_string_matcher (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [wsm_pkg::CFG_W-1:0]      cfg_wdata_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [wsm_pkg::ACT_W-1:0]      action_i,
  input  logic [wsm_pkg::CHAR_W-1:0]     char_byte_i,
  input  logic [wsm_pkg::PIDX_W-1:0]     pattern_index_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [wsm_pkg::COUNT_BITS-1:0] match_position_o,
  output logic [wsm_pkg::COUNT_BITS-1:0] match_count_o
);
  import wsm_pkg::*;

  logic [CFG_W-1:0]      cfg_len_q;
  logic [LEN_W-1:0]      eff_len;
  logic [LEN_W-1:0]      cur_len_q;
  logic [COUNT_BITS-1:0] seen_q, seen_d;
  logic [COUNT_BITS-1:0] seen_inc;
  stage_t                stage_q, stage_d;
  cell_ctl_t             ctl;
  logic                  rotating;
  logic                  advance;
  logic                  in_acc;
  logic                  text_acc;
  logic                  restart_acc;
  logic                  load_acc;
  logic [DIFF_W-1:0]     slot_raw;
  logic [DIFF_W-1:0]     slot_wrap;
  logic [IDX_W-1:0]      slot;

  logic [MAX_PATTERN-1:0][CHAR_W-1:0] w_row;
  logic [MAX_PATTERN-1:0][CHAR_W-1:0] q_row;
  logic [MAX_PATTERN-1:0]             agree_row;
  logic [MAX_PATTERN-1:0]             load_sel;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_len_q <= CFG_W'(1);
    end else if (cfg_we_i) begin
      cfg_len_q <= cfg_wdata_i;
    end
  end

  always_comb begin
    if (cfg_len_q == '0) begin
      eff_len = LEN_W'(1);
    end else if (LCMP_W'(cfg_len_q) > LCMP_W'(MAX_PATTERN)) begin
      eff_len = LEN_W'(MAX_PATTERN);
    end else begin
      eff_len = LEN_W'(cfg_len_q);
    end
  end

  // The pattern ring holds pattern[cur_len-1-j] in cell j.
  assign rotating = (cur_len_q != eff_len);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_len_q <= LEN_W'(1);
    end else if (cur_len_q < eff_len) begin
      cur_len_q <= cur_len_q + 1'b1;
    end else if (cur_len_q > eff_len) begin
      cur_len_q <= cur_len_q - 1'b1;
    end
  end

  assign in_ready_o  = !rotating && (!stage_q.valid || advance);
  assign in_acc      = in_valid_i && in_ready_o;
  assign text_acc    = in_acc && (action_i == ACT_TEXT);
  assign restart_acc = in_acc && (action_i == ACT_RESTART);
  assign load_acc    = in_acc && (action_i == ACT_LOAD) &&
                       (DIFF_W'(pattern_index_i) < DIFF_W'(MAX_PATTERN));

  // Ring slot of a pattern load, taken modulo the ring size.
  assign slot_raw  = DIFF_W'(cur_len_q) - DIFF_W'(1) - DIFF_W'(pattern_index_i);
  assign slot_wrap = slot_raw[DIFF_W-1] ? slot_raw + DIFF_W'(MAX_PATTERN) : slot_raw;
  assign slot      = slot_wrap[IDX_W-1:0];

  always_comb begin
    for (int j = 0; j < MAX_PATTERN; j++) begin
      load_sel[j] = (slot == IDX_W'(j));
    end
  end

  always_comb begin
    ctl         = '0;
    ctl.text_en = text_acc;
    ctl.load_en = load_acc;
    ctl.rot_up  = cur_len_q < eff_len;
    ctl.rot_dn  = cur_len_q > eff_len;
    ctl.chr     = char_byte_i;
  end

  for (genvar j = 0; j < MAX_PATTERN; j++) begin : g_cell
    localparam int PREV = (j == 0) ? MAX_PATTERN - 1 : j - 1;
    localparam int NEXT = (j == MAX_PATTERN - 1) ? 0 : j + 1;
    logic [CHAR_W-1:0] w_in;

    if (j == 0) begin : g_head
      assign w_in = char_byte_i;
    end else begin : g_body
      assign w_in = w_row[PREV];
    end

    wsm_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctl_i      (ctl),
      .load_sel_i (load_sel[j]),
      .w_prev_i   (w_in),
      .q_prev_i   (q_row[PREV]),
      .q_next_i   (q_row[NEXT]),
      .w_o        (w_row[j]),
      .q_o        (q_row[j]),
      .agree_o    (agree_row[j])
    );
  end

  // Window bytes left over from before a restart are never compared, since a
  // match needs at least a full pattern length of text since the restart.
  assign seen_inc = (seen_q == COUNT_TOP) ? COUNT_TOP : seen_q + 1'b1;

  always_comb begin
    seen_d = seen_q;
    if (restart_acc) begin
      seen_d = '0;
    end else if (text_acc) begin
      seen_d = seen_inc;
    end
  end

  always_comb begin
    stage_d = stage_q;
    if (text_acc) begin
      stage_d.valid = 1'b1;
      stage_d.ok    = seen_inc >= COUNT_BITS'(eff_len);
      stage_d.pos   = (seen_inc == COUNT_TOP) ? COUNT_TOP :
                      seen_inc - COUNT_BITS'(eff_len) + 1'b1;
    end else if (advance) begin
      stage_d.valid = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q  <= '0;
      stage_q <= '0;
    end else begin
      seen_q  <= seen_d;
      stage_q <= stage_d;
    end
  end

  wsm_result u_result (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .stage_i          (stage_q),
    .agree_i          (agree_row),
    .eff_len_i        (eff_len),
    .restart_i        (restart_acc),
    .out_ready_i      (out_ready_i),
    .advance_o        (advance),
    .out_valid_o      (out_valid_o),
    .match_position_o (match_position_o),
    .match_count_o    (match_count_o)
  );

endmodule

FILE: design/wsm_cell.sv
`timescale 1ns / 1ps

module wsm_cell (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  wsm_pkg::cell_ctl_t        ctl_i,
  input  logic                      load_sel_i,
  input  logic [wsm_pkg::CHAR_W-1:0] w_prev_i,
  input  logic [wsm_pkg::CHAR_W-1:0] q_prev_i,
  input  logic [wsm_pkg::CHAR_W-1:0] q_next_i,
  output logic [wsm_pkg::CHAR_W-1:0] w_o,
  output logic [wsm_pkg::CHAR_W-1:0] q_o,
  output logic                      agree_o
);
  import wsm_pkg::*;

  logic [CHAR_W-1:0] w_q;
  logic [CHAR_W-1:0] q_q;
  logic              agree_q;

  // w_q is this cell's text window byte, q_q the pattern byte aligned to it
  // for the current length. The pattern bytes form a ring that rotates by one
  // cell per cycle when the length changes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_q <= '0;
      q_q <= '0;
    end else begin
      if (ctl_i.text_en) begin
        w_q <= w_prev_i;
      end
      if (ctl_i.load_en && load_sel_i) begin
        q_q <= ctl_i.chr;
      end else if (ctl_i.rot_up) begin
        q_q <= q_prev_i;
      end else if (ctl_i.rot_dn) begin
        q_q <= q_next_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.text_en) begin
      agree_q <= chars_agree(w_prev_i, q_q);
    end
  end

  assign w_o     = w_q;
  assign q_o     = q_q;
  assign agree_o = agree_q;

endmodule

FILE: design/wsm_result.sv
`timescale 1ns / 1ps

module wsm_result (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  wsm_pkg::stage_t                stage_i,
  input  logic [wsm_pkg::MAX_PATTERN-1:0] agree_i,
  input  logic [wsm_pkg::LEN_W-1:0]      eff_len_i,
  input  logic                           restart_i,
  input  logic                           out_ready_i,
  output logic                           advance_o,
  output logic                           out_valid_o,
  output logic [wsm_pkg::COUNT_BITS-1:0] match_position_o,
  output logic [wsm_pkg::COUNT_BITS-1:0] match_count_o
);
  import wsm_pkg::*;

  logic                  out_valid_q, out_valid_d;
  logic [COUNT_BITS-1:0] pos_q;
  logic [COUNT_BITS-1:0] cnt_q;
  logic [COUNT_BITS-1:0] matches_q, matches_d;
  logic [COUNT_BITS-1:0] matches_inc;
  logic [MAX_PATTERN-1:0] pass;
  logic                  hit;

  // Cells beyond the current length do not take part in the compare.
  always_comb begin
    for (int j = 0; j < MAX_PATTERN; j++) begin
      pass[j] = agree_i[j] || (LEN_W'(j) >= eff_len_i);
    end
  end

  assign advance_o   = !out_valid_q || out_ready_i;
  assign hit         = stage_i.valid && stage_i.ok && (&pass);
  assign matches_inc = (matches_q == COUNT_TOP) ? COUNT_TOP : matches_q + 1'b1;

  always_comb begin
    out_valid_d = out_valid_q;
    matches_d   = matches_q;
    if (advance_o) begin
      out_valid_d = hit;
      if (hit) begin
        matches_d = matches_inc;
      end
    end
    // A restart beat always follows the text beat in the stage, so the
    // count of that beat is reported before the clear takes effect.
    if (restart_i) begin
      matches_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      matches_q   <= '0;
    end else begin
      out_valid_q <= out_valid_d;
      matches_q   <= matches_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_o && hit) begin
      pos_q <= stage_i.pos;
      cnt_q <= matches_inc;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign match_position_o = pos_q;
  assign match_count_o    = cnt_q;

endmodule

FILE: design/wsm_checker.sv
`timescale 1ns / 1ps

module wsm_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           in_valid_i,
  input logic                           in_ready_o,
  input logic [wsm_pkg::ACT_W-1:0]      action_i,
  input logic                           out_valid_o,
  input logic                           out_ready_i,
  input logic [wsm_pkg::COUNT_BITS-1:0] match_position_o,
  input logic [wsm_pkg::COUNT_BITS-1:0] match_count_o
);
  import wsm_pkg::*;

  logic text_beat;

  assign text_beat = in_valid_i && in_ready_o && (action_i == ACT_TEXT);

  // A stalled result beat holds its fields.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      out_valid_o && $stable(match_position_o) && $stable(match_count_o))
    else $error("result beat changed while stalled");

  // Every reported match is at least the first one since restart.
  a_count_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> match_count_o != '0)
    else $error("match count of zero reported");

  // Window start positions are one-based.
  a_pos_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> match_position_o != '0)
    else $error("match position of zero reported");

  // A newly raised result comes from an accepted text beat via the stage and result registers.
  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(text_beat, 2))
    else $error("result without a text beat two cycles earlier");

endmodule

bind wildcard_string_matcher wsm_checker u_wsm_checker (.*);

FILE: verif/wsm_match_checker.sv
`timescale 1ns / 1ps

module wsm_match_checker
  import wsm_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_W-1:0]      cfg_wdata_i,
  input  logic                  in_valid_i,
  input  logic                  in_ready_i,
  input  logic [ACT_W-1:0]      action_i,
  input  logic [CHAR_W-1:0]     char_byte_i,
  input  logic [PIDX_W-1:0]     pattern_index_i,
  input  logic                  out_valid_i,
  input  logic                  out_ready_i,
  input  logic [COUNT_BITS-1:0] match_position_i,
  input  logic [COUNT_BITS-1:0] match_count_i,
  output int                    mismatch_cnt_o,
  output int                    pending_cnt_o
);

  typedef struct packed {
    logic [COUNT_BITS-1:0] position;
    logic [COUNT_BITS-1:0] count;
  } match_t;

  logic [CHAR_W-1:0]     pattern_mem [MAX_PATTERN];
  logic [CHAR_W-1:0]     window_mem [MAX_PATTERN];
  logic [COUNT_BITS-1:0] bytes_seen;
  logic [COUNT_BITS-1:0] hits_seen;
  logic [CFG_W-1:0]      length_reg;
  match_t                match_q [$];
  int                    fail_cnt = 0;

  initial begin
    mismatch_cnt_o = 0;
    pending_cnt_o  = 0;
  end

  task automatic clear_window();
    int k;
    for (k = 0; k < MAX_PATTERN; k++) window_mem[k] = '0;
    bytes_seen = '0;
    hits_seen  = '0;
  endtask

  // Applies one accepted beat to the predicted state and queues any match.
  task automatic apply_beat(input logic [ACT_W-1:0] act, input logic [CHAR_W-1:0] chr,
                            input logic [PIDX_W-1:0] idx);
    int          k;
    int unsigned span;
    logic        hit;
    logic [CHAR_W-1:0] p;
    logic [CHAR_W-1:0] t;
    match_t      m;
    case (act)
      ACT_LOAD: begin
        if (idx < MAX_PATTERN) pattern_mem[idx] = chr;
      end
      ACT_RESTART: begin
        clear_window();
      end
      ACT_TEXT: begin
        for (k = MAX_PATTERN - 1; k > 0; k--) window_mem[k] = window_mem[k-1];
        window_mem[0] = chr;
        if (bytes_seen != COUNT_TOP) bytes_seen = bytes_seen + 1'b1;
        span = (length_reg == 0) ? 1 : ((length_reg > MAX_PATTERN) ? MAX_PATTERN : length_reg);
        if (bytes_seen >= span) begin
          hit = 1'b1;
          // Pattern position k lines up with the byte k places after the window start.
          for (k = 0; k < span; k++) begin
            p = pattern_mem[k];
            t = window_mem[span - 1 - k];
            if (p != t && p != WILDCARD && t != WILDCARD) hit = 1'b0;
          end
          if (hit) begin
            if (hits_seen != COUNT_TOP) hits_seen = hits_seen + 1'b1;
            m.position = (bytes_seen == COUNT_TOP) ? COUNT_TOP
                                                   : bytes_seen - COUNT_BITS'(span - 1);
            m.count    = hits_seen;
            match_q.push_back(m);
          end
        end
      end
      default: ;
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    match_t m;
    int     k;
    if (!rst_ni) begin
      for (k = 0; k < MAX_PATTERN; k++) pattern_mem[k] = '0;
      clear_window();
      length_reg = CFG_W'(1);
      match_q.delete();
      pending_cnt_o <= 0;
    end else begin
      if (cfg_we_i) length_reg = cfg_wdata_i;
      if (out_valid_i && out_ready_i) begin
        if (match_q.size() == 0) begin
          $error("match beat with none expected: position %0d count %0d",
                 match_position_i, match_count_i);
          fail_cnt++;
        end else begin
          m = match_q.pop_front();
          if (match_position_i !== m.position) begin
            $error("match_position: expected %0d, got %0d", m.position, match_position_i);
            fail_cnt++;
          end
          if (match_count_i !== m.count) begin
            $error("match_count: expected %0d, got %0d", m.count, match_count_i);
            fail_cnt++;
          end
        end
      end
      if (in_valid_i && in_ready_i) apply_beat(action_i, char_byte_i, pattern_index_i);
      pending_cnt_o  <= match_q.size();
      mismatch_cnt_o <= fail_cnt;
    end
  end

endmodule

FILE: verif/wildcard_string_matcher_test.sv
`timescale 1ns / 1ps

module wildcard_string_matcher_test;
  import wsm_pkg::*;

  localparam logic [ACT_W-1:0]  ACT_UNUSED     = ACT_W'(3);
  localparam logic [CHAR_W-1:0] CHAR_A         = 8'h61;
  localparam logic [CHAR_W-1:0] CHAR_B         = 8'h62;
  localparam int                WATCHDOG_LIMIT = 2000;

  logic                  clk_i           = 1'b0;
  logic                  rst_ni          = 1'b0;
  logic                  cfg_we_i        = 1'b0;
  logic [CFG_W-1:0]      cfg_wdata_i     = '0;
  logic                  in_valid_i      = 1'b0;
  logic                  in_ready_o;
  logic [ACT_W-1:0]      action_i        = ACT_TEXT;
  logic [CHAR_W-1:0]     char_byte_i     = '0;
  logic [PIDX_W-1:0]     pattern_index_i = '0;
  logic                  out_valid_o;
  logic                  out_ready_i     = 1'b0;
  logic [COUNT_BITS-1:0] match_position_o;
  logic [COUNT_BITS-1:0] match_count_o;

  int mismatches;
  int pending;
  int burst_left  = 1;
  int quiet_count = 0;

  wildcard_string_matcher dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .action_i         (action_i),
    .char_byte_i      (char_byte_i),
    .pattern_index_i  (pattern_index_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .match_position_o (match_position_o),
    .match_count_o    (match_count_o)
  );

  wsm_match_checker checker_inst (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_valid_i       (in_valid_i),
    .in_ready_i       (in_ready_o),
    .action_i         (action_i),
    .char_byte_i      (char_byte_i),
    .pattern_index_i  (pattern_index_i),
    .out_valid_i      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .match_position_i (match_position_o),
    .match_count_i    (match_count_o),
    .mismatch_cnt_o   (mismatches),
    .pending_cnt_o    (pending)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // The result side switches between free flow, random stalls and long stalls.
  always @(posedge clk_i) begin
    int rx_mode;
    int rx_left;
    if (rx_left <= 0) begin
      rx_mode = $urandom_range(0, 3);
      rx_left = $urandom_range(8, 60);
    end else begin
      rx_left--;
    end
    case (rx_mode)
      0:       out_ready_i <= 1'b1;
      1:       out_ready_i <= ($urandom_range(0, 1) == 1);
      2:       out_ready_i <= ($urandom_range(0, 4) == 0);
      default: out_ready_i <= (rx_left % 12 == 0);
    endcase
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || cfg_we_i || !rst_ni) begin
      quiet_count <= 0;
    end else begin
      quiet_count <= quiet_count + 1;
    end
    if (quiet_count >= WATCHDOG_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  function automatic logic [CHAR_W-1:0] pick_char(input int wild_pct);
    int r;
    r = $urandom_range(0, 99);
    if (r < wild_pct) return WILDCARD;
    r = $urandom_range(0, 19);
    if (r < 9) return CHAR_A;
    if (r < 18) return CHAR_B;
    if (r == 18) return 8'h00;
    return CHAR_W'($urandom_range(0, 255));
  endfunction

  // Holds one beat until it is accepted, then applies the burst and gap pacing.
  task automatic send_beat(input logic [ACT_W-1:0] act, input logic [CHAR_W-1:0] chr,
                           input logic [PIDX_W-1:0] idx);
    int gap;
    in_valid_i      <= 1'b1;
    action_i        <= act;
    char_byte_i     <= chr;
    pattern_index_i <= idx;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 10);
      gap = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  // The length register is only written once every expected match has drained.
  task automatic write_length(input logic [CFG_W-1:0] value);
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (4) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  initial begin
    int               ph;
    int               k;
    int               r;
    int               span;
    int               pat_wild;
    int               text_wild;
    int               n_text;
    logic [CFG_W-1:0] len_val;
    logic [CFG_W-1:0] phase_len [10];

    phase_len = '{7'd1, 7'd3, 7'd64, 7'd2, 7'd127, 7'd5, 7'd0, 7'd4, 7'd65, 7'd1};

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Length one against a zeroed pattern: zero bytes and wildcards both match.
    send_beat(ACT_TEXT, 8'h00, 6'h00);
    send_beat(ACT_TEXT, 8'hFF, 6'h3F);
    send_beat(ACT_TEXT, WILDCARD, 6'h15);
    send_beat(ACT_UNUSED, 8'hFF, 6'h3F);
    send_beat(ACT_LOAD, 8'hFF, 6'h3F);
    send_beat(ACT_LOAD, CHAR_A, 6'h00);
    send_beat(ACT_TEXT, CHAR_A, 6'h2A);
    send_beat(ACT_TEXT, CHAR_B, 6'h00);
    send_beat(ACT_RESTART, 8'hA5, 6'h2A);
    send_beat(ACT_TEXT, CHAR_A, 6'h00);
    send_beat(ACT_LOAD, WILDCARD, 6'h00);
    send_beat(ACT_TEXT, 8'h5A, 6'h00);
    write_length(7'd0);
    send_beat(ACT_TEXT, 8'h00, 6'h00);
    // Growing the length mid-stream: the window already holds older bytes.
    write_length(7'd2);
    send_beat(ACT_LOAD, CHAR_B, 6'h01);
    send_beat(ACT_TEXT, CHAR_B, 6'h00);
    send_beat(ACT_TEXT, WILDCARD, 6'h00);
    send_beat(ACT_TEXT, CHAR_A, 6'h00);

    for (ph = 0; ph < 10; ph++) begin
      len_val = (ph == 9) ? CFG_W'($urandom_range(1, 8)) : phase_len[ph];
      write_length(len_val);
      span = (len_val == 0) ? 1 : ((len_val > MAX_PATTERN) ? MAX_PATTERN : len_val);
      // Long patterns are mostly wildcards so that whole windows still agree.
      pat_wild  = (span > 8) ? 92 : 20;
      text_wild = (span > 8) ? 25 : 15;
      n_text    = (span > 8) ? 90 : 35;
      for (k = 0; k < span; k++) send_beat(ACT_LOAD, pick_char(pat_wild), PIDX_W'(k));
      if ($urandom_range(0, 1) == 1) begin
        send_beat(ACT_RESTART, CHAR_W'($urandom), PIDX_W'($urandom));
      end
      for (k = 0; k < n_text; k++) begin
        r = $urandom_range(0, 99);
        if (r < 2) begin
          send_beat(ACT_UNUSED, CHAR_W'($urandom), PIDX_W'($urandom));
        end else if (r < 4) begin
          send_beat(ACT_RESTART, CHAR_W'($urandom), PIDX_W'($urandom));
        end else if (r < 6) begin
          send_beat(ACT_LOAD, pick_char(pat_wild), PIDX_W'($urandom_range(0, 63)));
        end else begin
          send_beat(ACT_TEXT, pick_char(text_wild), PIDX_W'($urandom));
        end
      end
    end

    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (8) @(posedge clk_i);
    if (mismatches == 0 && pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

FILE: files.f
design/wsm_pkg.sv
design/wsm_cell.sv
design/wsm_result.sv
design/wildcard_string_matcher.sv
design/wsm_checker.sv
verif/wsm_match_checker.sv
verif/wildcard_string_matcher_test.sv
